// ===== rtl/csmv_pkg.sv =====
// Shared constants, codes and control types for the scaled CSR sparse mat-vec block.
// No dependencies; imported by csmv_if, csmv_dp and the top level (csmv_ram does not use it).
package csmv_pkg;

  // x vector store
  localparam int X_DEPTH = 1024;
  localparam int XA_W    = $clog2(X_DEPTH);

  // row counter
  localparam int MAX_ROWS = 65536;
  localparam int ROW_W    = 16;
  localparam int RCNT_W   = 17;

  // field and datapath widths
  localparam int ACT_W   = 2;
  localparam int IDX_W   = 10;
  localparam int VAL_W   = 32;
  localparam int ACC_W   = 64;
  localparam int PROD_W  = 2 * (VAL_W + 1);
  localparam int T_W     = 96;
  localparam int FRAC_W  = 16;
  localparam int RND_HALF = 32768;

  // configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;

  localparam logic [CFG_IDX_W-1:0] REG_ALPHA = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BETA  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ROWS  = 2'd2;

  localparam logic [VAL_W-1:0]  ALPHA_RST = 32'h0001_0000;
  localparam logic [VAL_W-1:0]  BETA_RST  = 32'h0000_0000;
  localparam logic [RCNT_W-1:0] ROWS_RST  = 17'd1;

  // item actions
  localparam logic [ACT_W-1:0] ACT_LOAD  = 2'd0;
  localparam logic [ACT_W-1:0] ACT_NZ    = 2'd1;
  localparam logic [ACT_W-1:0] ACT_EMPTY = 2'd2;
  localparam logic [ACT_W-1:0] ACT_NONE  = 2'd3;  // ignored by the block

  // Q16.16 clip limits
  localparam logic [VAL_W-1:0] Y_MAX = 32'h7FFF_FFFF;
  localparam logic [VAL_W-1:0] Y_MIN = 32'h8000_0000;

  // multiplier operand select
  localparam logic [1:0] OP_NZ  = 2'd0;  // value * x
  localparam logic [1:0] OP_ALO = 2'd1;  // alpha * acc[31:0] (unsigned)
  localparam logic [1:0] OP_AHI = 2'd2;  // alpha * acc[63:32]
  localparam logic [1:0] OP_BY  = 2'd3;  // beta * old_y

  // row-end sum register operation
  localparam logic [1:0] T_HOLD = 2'd0;
  localparam logic [1:0] T_LO   = 2'd1;  // t = prod + half
  localparam logic [1:0] T_HI   = 2'd2;  // t += prod << 32
  localparam logic [1:0] T_BY   = 2'd3;  // t += prod

  typedef struct packed {
    logic [1:0] op_sel;
    logic       acc_add;
    logic       acc_clear;
    logic [1:0] t_op;
  } dp_ctrl_t;

endpackage

// ===== rtl/csmv_if.sv =====
// Valid/ready channel interfaces for input items and row results.
// Depends on csmv_pkg for field widths.
interface csmv_in_if import csmv_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic [ACT_W-1:0]        action;
  logic [IDX_W-1:0]        index;
  logic signed [VAL_W-1:0] value;
  logic                    last_in_row;
  logic signed [VAL_W-1:0] old_y;

  modport source (output valid, action, index, value, last_in_row, old_y, input ready);
  modport sink   (input valid, action, index, value, last_in_row, old_y, output ready);
endinterface

interface csmv_out_if import csmv_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic [ROW_W-1:0]        row_index;
  logic signed [VAL_W-1:0] new_y;
  logic                    saturated;

  modport source (output valid, row_index, new_y, saturated, input ready);
  modport sink   (input valid, row_index, new_y, saturated, output ready);
endinterface

// ===== rtl/csr_sparse_matvec_scaled.sv =====
// Scaled CSR sparse mat-vec, y = alpha*A*x + beta*y, x held in a 1024x32 RAM.
// An x load leaves the sequencer idle; a nonzero takes RAM read, multiply and accumulate,
// and a row close uses the one shared multiplier in S_C0..S_C3, then outputs from S_FIN.
// Input is not ready until idle again; an empty row goes straight to the close.
// Sync reset clears accumulator, row counter and config to defaults; x RAM is not cleared.
module csr_sparse_matvec_scaled import csmv_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_write,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  csmv_in_if.sink               items,
  csmv_out_if.source            results
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_MUL  = 3'd1;
  localparam logic [2:0] S_ACC  = 3'd2;
  localparam logic [2:0] S_C0   = 3'd3;
  localparam logic [2:0] S_C1   = 3'd4;
  localparam logic [2:0] S_C2   = 3'd5;
  localparam logic [2:0] S_C3   = 3'd6;
  localparam logic [2:0] S_FIN  = 3'd7;

  logic [2:0]              state;
  logic [2:0]              state_next;
  logic signed [VAL_W-1:0] alpha;
  logic signed [VAL_W-1:0] beta;
  logic [RCNT_W-1:0]       row_count;
  logic [RCNT_W-1:0]       eff_rows;
  logic [ROW_W-1:0]        row_cnt;
  logic [RCNT_W-1:0]       cnt_inc;
  logic                    accept;
  logic                    in_range;
  logic                    ram_en;
  logic                    ram_we;
  logic [VAL_W-1:0]        ram_rdata;
  logic signed [VAL_W-1:0] value_q;
  logic signed [VAL_W-1:0] old_y_q;
  logic                    last_q;
  logic                    col_ok_q;
  logic signed [VAL_W-1:0] xval;
  logic signed [VAL_W-1:0] res;
  logic                    res_sat;
  logic                    fin_go;
  dp_ctrl_t                ctrl;
  logic                    out_valid;
  logic [ROW_W-1:0]        out_row;
  logic signed [VAL_W-1:0] out_y;
  logic                    out_sat;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      alpha     <= ALPHA_RST;
      beta      <= BETA_RST;
      row_count <= ROWS_RST;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_ALPHA: alpha     <= cfg_data[VAL_W-1:0];
        REG_BETA:  beta      <= cfg_data[VAL_W-1:0];
        REG_ROWS:  row_count <= cfg_data[RCNT_W-1:0];
        default: ;
      endcase
    end
  end

  assign items.ready = (state == S_IDLE);
  assign accept      = items.valid & items.ready;
  assign in_range    = (int'(items.index) < X_DEPTH);
  assign ram_we      = accept && (items.action == ACT_LOAD) && in_range;
  assign ram_en      = ram_we || (accept && (items.action == ACT_NZ));

  csmv_ram #(
    .WIDTH (VAL_W),
    .DEPTH (X_DEPTH)
  ) u_xram (
    .clk   (clk),
    .en    (ram_en),
    .we    (ram_we),
    .addr  (XA_W'(items.index)),
    .wdata (items.value),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (accept) begin
      value_q  <= items.value;
      old_y_q  <= items.old_y;
      last_q   <= items.last_in_row;
      col_ok_q <= in_range;
    end
  end

  // column beyond the store multiplies by zero
  assign xval = col_ok_q ? ram_rdata : '0;

  assign fin_go = ~out_valid | results.ready;

  always_comb begin
    ctrl       = '{op_sel: OP_NZ, acc_add: 1'b0, acc_clear: 1'b0, t_op: T_HOLD};
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (accept && (items.action == ACT_NZ)) begin
          state_next = S_MUL;
        end else if (accept && (items.action == ACT_EMPTY)) begin
          state_next = S_C0;
        end
      end
      S_MUL: begin
        ctrl.op_sel = OP_NZ;
        state_next  = S_ACC;
      end
      S_ACC: begin
        ctrl.acc_add = 1'b1;
        state_next   = last_q ? S_C0 : S_IDLE;
      end
      S_C0: begin
        ctrl.op_sel = OP_ALO;
        state_next  = S_C1;
      end
      S_C1: begin
        ctrl.op_sel = OP_AHI;
        ctrl.t_op   = T_LO;
        state_next  = S_C2;
      end
      S_C2: begin
        ctrl.op_sel = OP_BY;
        ctrl.t_op   = T_HI;
        state_next  = S_C3;
      end
      S_C3: begin
        ctrl.t_op  = T_BY;
        state_next = S_FIN;
      end
      S_FIN: begin
        ctrl.acc_clear = fin_go;
        if (fin_go) begin
          state_next = S_IDLE;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  csmv_dp u_dp (
    .clk     (clk),
    .rst     (rst),
    .ctrl    (ctrl),
    .value   (value_q),
    .xval    (xval),
    .alpha   (alpha),
    .beta    (beta),
    .old_y   (old_y_q),
    .res     (res),
    .res_sat (res_sat)
  );

  // row count clamped to 1..MAX_ROWS; counter wraps once it reaches it
  always_comb begin
    if (row_count == '0) begin
      eff_rows = RCNT_W'(1);
    end else if (row_count > RCNT_W'(MAX_ROWS)) begin
      eff_rows = RCNT_W'(MAX_ROWS);
    end else begin
      eff_rows = row_count;
    end
  end

  assign cnt_inc = {1'b0, row_cnt} + RCNT_W'(1);

  always_ff @(posedge clk) begin
    if (rst) begin
      row_cnt <= '0;
    end else if (state == S_FIN && fin_go) begin
      row_cnt <= (cnt_inc >= eff_rows) ? '0 : cnt_inc[ROW_W-1:0];
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == S_FIN && fin_go) begin
      out_valid <= 1'b1;
    end else if (results.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_FIN && fin_go) begin
      out_row <= row_cnt;
      out_y   <= res;
      out_sat <= res_sat;
    end
  end

  assign results.valid     = out_valid;
  assign results.row_index = out_row;
  assign results.new_y     = out_y;
  assign results.saturated = out_sat;

  // a nonzero transaction always starts the multiply sequence
  a_nz_starts: assert property (@(posedge clk) disable iff (rst)
    (accept && items.action == ACT_NZ) |=> (state == S_MUL))
    else $error("nonzero accepted without entering multiply");

  // a pending result is never overwritten by a row close
  a_fin_waits: assert property (@(posedge clk) disable iff (rst)
    (state == S_FIN && out_valid && !results.ready) |=> (state == S_FIN))
    else $error("row close left while output slot busy");

  // results only appear out of the row-close state
  a_out_src: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> ($past(state) == S_FIN))
    else $error("result raised outside row close");

  // an accepted empty row drops input ready as the row close begins
  a_busy_no_accept: assert property (@(posedge clk) disable iff (rst)
    (accept && items.action == ACT_EMPTY) |=> !items.ready)
    else $error("input taken during row close");

endmodule

// ===== rtl/csmv_ram.sv =====
// Generic single-port synchronous RAM with registered read.
// No dependencies.
module csmv_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     en,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (en) begin
      if (we) begin
        mem[addr] <= wdata;
      end else begin
        rdata <= mem[addr];
      end
    end
  end

endmodule

// ===== rtl/csmv_dp.sv =====
// Arithmetic datapath: shared 33x33 multiplier, row accumulator, row-end sum and clip.
// Depends on csmv_pkg; sequenced by the top level through dp_ctrl_t.
module csmv_dp import csmv_pkg::*; (
  input  logic                    clk,
  input  logic                    rst,
  input  dp_ctrl_t                ctrl,
  input  logic signed [VAL_W-1:0] value,
  input  logic signed [VAL_W-1:0] xval,
  input  logic signed [VAL_W-1:0] alpha,
  input  logic signed [VAL_W-1:0] beta,
  input  logic signed [VAL_W-1:0] old_y,
  output logic signed [VAL_W-1:0] res,
  output logic                    res_sat
);

  logic signed [ACC_W-1:0]  acc;
  logic                     acc_clip;
  logic signed [VAL_W:0]    mul_a;
  logic signed [VAL_W:0]    mul_b;
  logic signed [PROD_W-1:0] prod;
  logic signed [ACC_W-1:0]  p_q;
  logic signed [ACC_W-1:0]  rnd;
  logic [ACC_W:0]           sum;
  logic                     ovf;
  logic [ACC_W-1:0]         acc_next;
  logic [T_W-1:0]           t;
  logic [T_W-1:0]           t_next;
  logic [T_W-1:0]           prod_ext;
  logic                     hi_ok;

  always_comb begin
    unique case (ctrl.op_sel)
      OP_NZ: begin
        mul_a = {value[VAL_W-1], value};
        mul_b = {xval[VAL_W-1], xval};
      end
      OP_ALO: begin
        mul_a = {alpha[VAL_W-1], alpha};
        mul_b = {1'b0, acc[VAL_W-1:0]};
      end
      OP_AHI: begin
        mul_a = {alpha[VAL_W-1], alpha};
        mul_b = {acc[ACC_W-1], acc[ACC_W-1:VAL_W]};
      end
      OP_BY: begin
        mul_a = {beta[VAL_W-1], beta};
        mul_b = {old_y[VAL_W-1], old_y};
      end
    endcase
  end

  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
  end

  // round product to Q16.16 (floor of p + half), saturating add into accumulator
  assign p_q = prod[ACC_W-1:0] + ACC_W'(RND_HALF);
  assign rnd = p_q >>> FRAC_W;
  assign sum = {acc[ACC_W-1], acc} + {rnd[ACC_W-1], rnd};
  assign ovf = sum[ACC_W] ^ sum[ACC_W-1];

  always_comb begin
    if (!ovf) begin
      acc_next = sum[ACC_W-1:0];
    end else if (sum[ACC_W]) begin
      acc_next = {1'b1, {(ACC_W-1){1'b0}}};
    end else begin
      acc_next = {1'b0, {(ACC_W-1){1'b1}}};
    end
  end

  always_ff @(posedge clk) begin
    if (rst || ctrl.acc_clear) begin
      acc      <= '0;
      acc_clip <= 1'b0;
    end else if (ctrl.acc_add) begin
      acc <= acc_next;
      if (ovf) begin
        acc_clip <= 1'b1;
      end
    end
  end

  // row-end sum: alpha*acc + beta*old_y + half, exact in 96 bits
  assign prod_ext = {{(T_W-PROD_W){prod[PROD_W-1]}}, prod};

  always_comb begin
    unique case (ctrl.t_op)
      T_HOLD: t_next = t;
      T_LO:   t_next = prod_ext + T_W'(RND_HALF);
      T_HI:   t_next = t + {prod[ACC_W-1:0], {(T_W-ACC_W){1'b0}}};
      T_BY:   t_next = t + prod_ext;
    endcase
  end

  always_ff @(posedge clk) begin
    t <= t_next;
  end

  // result is t >>> 16; fits Q16.16 when bits 95..47 all match the sign
  assign hi_ok   = (&t[T_W-1:FRAC_W+VAL_W-1]) | ~(|t[T_W-1:FRAC_W+VAL_W-1]);
  assign res     = hi_ok ? t[FRAC_W+VAL_W-1:FRAC_W] : (t[T_W-1] ? Y_MIN : Y_MAX);
  assign res_sat = ~hi_ok | acc_clip;

endmodule

// ===== tb/sv/tb_csr_sparse_matvec_scaled.sv =====
// Self-checking testbench for csr_sparse_matvec_scaled: random CSR row streams against an
// in-bench predictor of y = alpha*A*x + beta*y. Depends on csmv_pkg, csmv_if and the block.
`timescale 1ns / 100ps

module tb_csr_sparse_matvec_scaled;
  import csmv_pkg::*;

  localparam int TAIL_CYCLES = 24;   // covers row close latency after the last transaction
  localparam int LONG_HOLD   = 400;  // result-side hold to back up the pipeline
  localparam int IDLE_PCT    = 11;

  typedef struct {
    logic [ACT_W-1:0]        action;
    logic [IDX_W-1:0]        index;
    logic signed [VAL_W-1:0] value;
    logic                    last_in_row;
    logic signed [VAL_W-1:0] old_y;
  } mv_item_t;

  typedef struct {
    logic [ROW_W-1:0]        row_index;
    logic signed [VAL_W-1:0] new_y;
    logic                    saturated;
  } y_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_write = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  csmv_in_if  items_ch ();
  csmv_out_if results_ch ();

  csr_sparse_matvec_scaled DUT (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .items     (items_ch),
    .results   (results_ch)
  );

  always #1 clk = ~clk;

  initial begin
    items_ch.valid       = 1'b0;
    items_ch.action      = ACT_LOAD;
    items_ch.index       = '0;
    items_ch.value       = '0;
    items_ch.last_in_row = 1'b0;
    items_ch.old_y       = '0;
    results_ch.ready     = 1'b0;
  end

  // stimulus and expectations
  mv_item_t  item_feed[$];
  y_result_t y_expected[$];
  int        errors = 0;

  logic no_idle = 1'b0;
  logic stall_req = 1'b0;
  logic stall_started = 1'b0;
  int   stall_left = 0;
  logic in_taken = 1'b0;

  // columns of x already loaded, so nonzeros never hit an unwritten entry
  logic x_known [X_DEPTH];
  int   x_cols[$];

  // predictor state
  logic signed [VAL_W-1:0] xs [X_DEPTH];
  logic signed [ACC_W-1:0] row_acc = '0;
  logic                    acc_sat = 1'b0;
  logic [ROW_W-1:0]        row_ctr = '0;
  logic signed [VAL_W-1:0] alpha_q = ALPHA_RST;
  logic signed [VAL_W-1:0] beta_q  = BETA_RST;
  logic [RCNT_W-1:0]       rows_cfg = ROWS_RST;

  initial begin
    for (int i = 0; i < X_DEPTH; i++) x_known[i] = 1'b0;
  end

  function automatic void close_row_predict(logic signed [VAL_W-1:0] oy);
    logic signed [127:0] t;
    logic signed [127:0] sh;
    y_result_t r;
    int unsigned eff;
    t  = alpha_q * row_acc + beta_q * oy + 128'sd32768;
    sh = t >>> FRAC_W;
    r.row_index = row_ctr;
    r.saturated = acc_sat;
    if (sh > 128'sd2147483647) begin
      r.new_y = Y_MAX;
      r.saturated = 1'b1;
    end else if (sh < -128'sd2147483648) begin
      r.new_y = Y_MIN;
      r.saturated = 1'b1;
    end else begin
      r.new_y = sh[VAL_W-1:0];
    end
    y_expected.push_back(r);
    eff = 32'(rows_cfg);
    if (eff < 1) eff = 1;
    if (eff > MAX_ROWS) eff = MAX_ROWS;
    if (int'(row_ctr) + 1 >= eff) row_ctr = '0;
    else row_ctr = row_ctr + 1'b1;
    row_acc = '0;
    acc_sat = 1'b0;
  endfunction

  function automatic void predict_row_update(mv_item_t it);
    logic signed [63:0] prod;
    logic signed [63:0] rnd;
    logic signed [64:0] sum65;
    case (it.action)
      ACT_LOAD: xs[it.index] = it.value;
      ACT_NZ: begin
        prod  = it.value * xs[it.index];
        rnd   = (prod + 64'sd32768) >>> FRAC_W;
        sum65 = row_acc + rnd;
        if (sum65[64] != sum65[63]) begin
          row_acc = sum65[64] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
          acc_sat = 1'b1;
        end else begin
          row_acc = sum65[63:0];
        end
        if (it.last_in_row) close_row_predict(it.old_y);
      end
      ACT_EMPTY: close_row_predict(it.old_y);
      default: ;  // unused action does nothing
    endcase
  endfunction

  // input driver: next transaction presented on the falling edge
  always @(negedge clk) begin
    mv_item_t nxt;
    logic go;
    if (rst) begin
      items_ch.valid <= 1'b0;
    end else if (!items_ch.valid || in_taken) begin
      go = (item_feed.size() != 0) && (no_idle || $urandom_range(0, 99) >= IDLE_PCT);
      if (go) begin
        nxt = item_feed.pop_front();
        items_ch.valid       <= 1'b1;
        items_ch.action      <= nxt.action;
        items_ch.index       <= nxt.index;
        items_ch.value       <= nxt.value;
        items_ch.last_in_row <= nxt.last_in_row;
        items_ch.old_y       <= nxt.old_y;
      end else begin
        items_ch.valid <= 1'b0;
      end
    end
  end

  // result ready: random idling plus one long hold
  always @(negedge clk) begin
    if (stall_req && !stall_started) begin
      stall_started    <= 1'b1;
      stall_left       <= LONG_HOLD;
      results_ch.ready <= 1'b0;
    end else if (stall_left != 0) begin
      stall_left       <= stall_left - 1;
      results_ch.ready <= 1'b0;
    end else begin
      results_ch.ready <= no_idle || ($urandom_range(0, 99) >= IDLE_PCT);
    end
  end

  // monitor: check results first, then predict from the accepted input transaction
  always @(posedge clk) begin
    mv_item_t  got;
    y_result_t want;
    in_taken <= !rst && items_ch.valid && items_ch.ready;
    if (!rst && results_ch.valid && results_ch.ready) begin
      if (y_expected.size() == 0) begin
        $error("unexpected result: row_index %0d new_y %0d saturated %0b",
               results_ch.row_index, results_ch.new_y, results_ch.saturated);
        errors++;
      end else begin
        want = y_expected.pop_front();
        if (results_ch.row_index !== want.row_index) begin
          $error("row_index mismatch: expected %0d, actual %0d",
                 want.row_index, results_ch.row_index);
          errors++;
        end
        if (results_ch.new_y !== want.new_y) begin
          $error("new_y mismatch: expected %0d, actual %0d", want.new_y, results_ch.new_y);
          errors++;
        end
        if (results_ch.saturated !== want.saturated) begin
          $error("saturated mismatch: expected %0b, actual %0b",
                 want.saturated, results_ch.saturated);
          errors++;
        end
      end
    end
    if (!rst && items_ch.valid && items_ch.ready) begin
      got.action      = items_ch.action;
      got.index       = items_ch.index;
      got.value       = items_ch.value;
      got.last_in_row = items_ch.last_in_row;
      got.old_y       = items_ch.old_y;
      predict_row_update(got);
    end
  end

  // ---- stimulus helpers ----
  function automatic void push_item(logic [ACT_W-1:0] act, logic [IDX_W-1:0] idx,
                                    logic signed [VAL_W-1:0] val, logic last,
                                    logic signed [VAL_W-1:0] oy);
    mv_item_t it;
    it.action = act;
    it.index = idx;
    it.value = val;
    it.last_in_row = last;
    it.old_y = oy;
    item_feed.push_back(it);
    if (act == ACT_LOAD && !x_known[idx]) begin
      x_known[idx] = 1'b1;
      x_cols.push_back(int'(idx));
    end
  endfunction

  function automatic logic signed [VAL_W-1:0] rand_val();
    case ($urandom_range(0, 9))
      0: return Y_MAX;
      1: return Y_MIN;
      2: return '0;
      3, 4, 5: return int'($urandom_range(0, 2097152)) - 1048576;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic signed [VAL_W-1:0] rand_scale();
    case ($urandom_range(0, 9))
      0: return 32'sd65536;
      1: return Y_MAX;
      2: return Y_MIN;
      3: return '0;
      4, 5, 6, 7: return int'($urandom_range(0, 524288)) - 262144;
      default: return $urandom;
    endcase
  endfunction

  function automatic int gen_load();
    push_item(ACT_LOAD, IDX_W'($urandom_range(0, X_DEPTH - 1)), rand_val(),
              1'($urandom_range(0, 1)), $urandom);
    return 1;
  endfunction

  // one CSR row; now and then a load or a dead action inside it, or a close by empty row
  function automatic int gen_row(int nnz);
    int cnt;
    logic [IDX_W-1:0] col;
    cnt = 0;
    for (int k = 0; k < nnz; k++) begin
      if ($urandom_range(0, 19) == 0) cnt += gen_load();
      if ($urandom_range(0, 29) == 0)
        push_item(ACT_NONE, IDX_W'($urandom), $urandom, 1'($urandom_range(0, 1)), $urandom);
      col = IDX_W'(x_cols[$urandom_range(0, x_cols.size() - 1)]);
      if (k == nnz - 1 && $urandom_range(0, 14) == 0) begin
        push_item(ACT_NZ, col, rand_val(), 1'b0, $urandom);
        push_item(ACT_EMPTY, IDX_W'($urandom), $urandom, 1'($urandom_range(0, 1)),
                  rand_val());
        cnt += 2;
      end else begin
        push_item(ACT_NZ, col, rand_val(), k == nnz - 1, rand_val());
        cnt++;
      end
    end
    if (nnz == 0) begin
      push_item(ACT_EMPTY, IDX_W'($urandom), $urandom, 1'($urandom_range(0, 1)), rand_val());
      cnt++;
    end
    return cnt;
  endfunction

  function automatic void gen_phase(int n);
    int cnt;
    int pick;
    cnt = 0;
    while (cnt < n) begin
      if ($urandom_range(0, 99) < 15) begin
        cnt += gen_load();
      end else begin
        pick = $urandom_range(0, 9);
        if (pick == 0) cnt += gen_row(0);
        else if (pick <= 7) cnt += gen_row($urandom_range(1, 4));
        else cnt += gen_row($urandom_range(5, 8));
      end
    end
  endfunction

  task automatic cfg_put(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(negedge clk);
    cfg_write <= 1'b0;
    case (idx)
      REG_ALPHA: alpha_q = data;
      REG_BETA:  beta_q = data;
      REG_ROWS:  rows_cfg = data[RCNT_W-1:0];
      default: ;
    endcase
  endtask

  task automatic program_regs(logic [31:0] a, logic [31:0] b, logic [31:0] rows);
    cfg_put(REG_ALPHA, a);
    cfg_put(REG_BETA, b);
    cfg_put(REG_ROWS, rows);
  endtask

  // wait until every transaction is in and every result is out, then let the pipe settle
  task automatic drain();
    while (item_feed.size() != 0 || items_ch.valid) @(posedge clk);
    while (y_expected.size() != 0) @(negedge clk);
    repeat (TAIL_CYCLES) @(negedge clk);
  endtask

  initial begin
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed: x extremes, rounding halves, mid-row load, dead action, mid-row close
    push_item(ACT_LOAD, 10'd0, Y_MAX, 1'b1, Y_MIN);
    push_item(ACT_LOAD, 10'd1023, Y_MIN, 1'b0, Y_MAX);
    push_item(ACT_LOAD, 10'd1, 32'sh0001_0000, 1'b0, '0);
    push_item(ACT_LOAD, 10'd2, 32'shFFFF_0000, 1'b0, '0);
    push_item(ACT_LOAD, 10'd3, '0, 1'b0, '0);
    push_item(ACT_LOAD, 10'd5, 32'sd1, 1'b0, '0);
    push_item(ACT_NZ, 10'd1, 32'sh0002_8000, 1'b1, '0);
    push_item(ACT_NZ, 10'd0, Y_MAX, 1'b1, Y_MAX);
    push_item(ACT_NZ, 10'd1023, Y_MIN, 1'b0, '0);
    push_item(ACT_NZ, 10'd0, Y_MIN, 1'b1, Y_MIN);
    push_item(ACT_EMPTY, 10'd0, '0, 1'b0, Y_MAX);
    push_item(ACT_NZ, 10'd2, 32'sd5, 1'b0, '0);
    push_item(ACT_LOAD, 10'd4, 32'sh0003_0000, 1'b0, '0);
    push_item(ACT_NONE, 10'h3FF, '1, 1'b1, '1);
    push_item(ACT_NZ, 10'd4, 32'sh0001_0000, 1'b1, '0);
    push_item(ACT_NZ, 10'd1, 32'sd12345, 1'b0, '0);
    push_item(ACT_EMPTY, 10'd0, '0, 1'b1, Y_MIN);
    push_item(ACT_NZ, 10'd5, 32'sh0000_8000, 1'b1, '0);
    push_item(ACT_NZ, 10'd5, -32'sh0000_8000, 1'b1, '0);
    push_item(ACT_NZ, 10'd3, Y_MAX, 1'b1, '0);
    drain();

    // scale extremes, row count zero acts as one
    program_regs(Y_MAX, Y_MIN, 32'd0);
    push_item(ACT_EMPTY, 10'd0, '0, 1'b0, Y_MAX);
    push_item(ACT_EMPTY, 10'd0, '0, 1'b0, Y_MIN);
    push_item(ACT_NZ, 10'd1, 32'sh0001_0000, 1'b1, '0);
    drain();

    for (int ph = 0; ph < 8; ph++) begin
      case (ph)
        0: program_regs(32'd65536, 32'd65536, 32'd7);
        1: program_regs(rand_scale(), rand_scale(), MAX_ROWS);
        2: program_regs(Y_MIN, Y_MAX, 32'd3);   // counter likely past the count here
        3: program_regs('0, Y_MIN, 32'd0);
        4: program_regs(rand_scale(), '0, 32'h1_FFFF);
        5: program_regs(rand_scale(), rand_scale(), $urandom);
        default: program_regs(rand_scale(), rand_scale(), $urandom_range(1, 40));
      endcase
      no_idle = (ph == 0);
      gen_phase(205);
      if (ph == 1) stall_req = 1'b1;
      drain();
      no_idle = 1'b0;
    end

    if (errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  initial begin
    #1000000;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule

// ===== csr_sparse_matvec_scaled.f =====
rtl/csmv_pkg.sv
rtl/csmv_if.sv
rtl/csmv_ram.sv
rtl/csmv_dp.sv
rtl/csr_sparse_matvec_scaled.sv
tb/sv/tb_csr_sparse_matvec_scaled.sv
